// ===== design/periodic_grid_bilinear_lookup_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_GRID_BILINEAR_LOOKUP_UNIT_MACROS_SVH
`define PERIODIC_GRID_BILINEAR_LOOKUP_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define PGBL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PGBL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PGBL_ASSERT_IMP(lbl, ante, cons, msg)

`define PGBL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/pgbl_pkg.sv =====
// ----------------------------------------------------------------------------
// pgbl_pkg
// Types and constants of the periodic grid bilinear lookup unit.
// ----------------------------------------------------------------------------
package pgbl_pkg;

    localparam int DEF_GRID_W = 1440;
    localparam int DEF_GRID_H = 720;

    localparam int FRAC_BITS  = 14;
    localparam int FRAC_ONE   = 1 << FRAC_BITS;
    localparam int LAT_OFFSET = 5898240;

    localparam int LON_W  = 26;
    localparam int LAT_W  = 24;
    localparam int POS_W  = 25;
    localparam int SMP_W  = 16;
    localparam int LROW_W = 10;
    localparam int LCOL_W = 11;

    localparam int RECIP_SH = 26;
    localparam int NBR      = 4;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef logic [FRAC_BITS-1:0]    t_frac;
    typedef logic signed [SMP_W-1:0] t_smp;

    typedef struct packed {
        logic  isq;
        logic  we;
        t_smp  smp;
        t_frac fx;
        t_frac fy;
    } t_tag;

    typedef struct packed {
        t_smp  a;
        t_smp  b;
        t_smp  c;
        t_smp  d;
        t_frac fx;
        t_frac fy;
    } t_set;

endpackage

// ===== design/pgbl_in_if.sv =====
// ----------------------------------------------------------------------------
// pgbl_in_if
// Request channel: load or query transactions.
// ----------------------------------------------------------------------------
interface pgbl_in_if
    import pgbl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [0:0]               func;
    logic [LROW_W-1:0]        load_row;
    logic [LCOL_W-1:0]        load_col;
    logic signed [SMP_W-1:0]  sample;
    logic signed [LON_W-1:0]  longitude;
    logic signed [LAT_W-1:0]  latitude;

    modport source (
        output valid, func, load_row, load_col, sample, longitude, latitude,
        input  ready
    );

    modport sink (
        input  valid, func, load_row, load_col, sample, longitude, latitude,
        output ready
    );
endinterface

// ===== design/pgbl_out_if.sv =====
// ----------------------------------------------------------------------------
// pgbl_out_if
// Response channel: interpolated height transactions.
// ----------------------------------------------------------------------------
interface pgbl_out_if
    import pgbl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] height;

    modport source (
        output valid, height,
        input  ready
    );

    modport sink (
        input  valid, height,
        output ready
    );
endinterface

// ===== design/pgbl_front.sv =====
// ----------------------------------------------------------------------------
// pgbl_front
// Six-stage address pipeline: splits positions, wraps indices by reciprocal
// multiplication, forms the four neighbour addresses or the load address.
// ----------------------------------------------------------------------------
module pgbl_front
    import pgbl_pkg::*;
#(
    parameter int GRID_W = DEF_GRID_W,
    parameter int GRID_H = DEF_GRID_H,
    parameter int AW     = $clog2(DEF_GRID_W * DEF_GRID_H)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pgbl_in_if.sink       i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output t_tag          o_tag,
    output logic [AW-1:0] o_addr [NBR]
);

    localparam int NST  = 6;
    localparam int CW   = $clog2(GRID_W);
    localparam int RW   = $clog2(GRID_H);
    localparam int IP_W = LON_W - FRAC_BITS;
    localparam int IQ_W = POS_W - FRAC_BITS;
    localparam int KCOL = ((2 ** (IP_W - 1) + GRID_W - 1) / GRID_W) * GRID_W;
    localparam int KROW = ((2 ** (IQ_W - 1) + GRID_H - 1) / GRID_H) * GRID_H;
    localparam int UCW  = $clog2(KCOL + 2 ** (IP_W - 1));
    localparam int URW  = $clog2(KROW + 2 ** (IQ_W - 1));
    localparam int RMCW = UCW + 1;
    localparam int RMRW = URW + 1;
    localparam int PCW  = UCW + RECIP_SH;
    localparam int PRW  = URW + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RCP_W = RECIP_SH'(2 ** RECIP_SH / GRID_W);
    localparam logic [RECIP_SH-1:0] RCP_H = RECIP_SH'(2 ** RECIP_SH / GRID_H);

    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;

    // stage 1
    logic signed [IP_W-1:0]  ip;
    logic signed [IQ_W-1:0]  iq;
    logic signed [POS_W-1:0] qpos;
    t_tag                    n1_tag;
    logic [UCW-1:0]          n1_ucol;
    logic [URW-1:0]          n1_urow;
    t_tag                    r1_tag;
    logic [UCW-1:0]          r1_ucol;
    logic [URW-1:0]          r1_urow;
    logic [LROW_W-1:0]       r1_lrow;
    logic [LCOL_W-1:0]       r1_lcol;

    // stage 2
    logic [PCW-1:0]    pcol;
    logic [PRW-1:0]    prow;
    t_tag              r2_tag;
    logic [UCW-1:0]    r2_ucol;
    logic [URW-1:0]    r2_urow;
    logic [UCW-1:0]    r2_qcol;
    logic [URW-1:0]    r2_qrow;
    logic [LROW_W-1:0] r2_lrow;
    logic [LCOL_W-1:0] r2_lcol;

    // stage 3
    t_tag              r3_tag;
    logic [RMCW-1:0]   r3_rcol;
    logic [RMRW-1:0]   r3_rrow;
    logic [LROW_W-1:0] r3_lrow;
    logic [LCOL_W-1:0] r3_lcol;

    // stage 4
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
    logic [RW-1:0] w0;
    logic [RW-1:0] w1;
    t_tag          r4_tag;
    logic [CW-1:0] r4_c0;
    logic [CW-1:0] r4_c1;
    logic [RW-1:0] r4_r0;
    logic [RW-1:0] r4_r1;

    // stage 5
    t_tag          r5_tag;
    logic [AW-1:0] r5_base0;
    logic [AW-1:0] r5_base1;
    logic [CW-1:0] r5_c0;
    logic [CW-1:0] r5_c1;

    // stage 6
    t_tag          r6_tag;
    logic [AW-1:0] r6_addr [NBR];

    always_comb begin
        adv[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign i_req.ready = adv[0];
    assign o_valid     = r_v[NST-1];
    assign o_tag       = r6_tag;
    assign o_addr      = r6_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // position split: integer part floored, fraction in 1/16384
    always_comb begin
        ip           = $signed(i_req.longitude[LON_W-1:FRAC_BITS]);
        qpos         = $signed(POS_W'(LAT_OFFSET)) - POS_W'(i_req.latitude);
        iq           = $signed(qpos[POS_W-1:FRAC_BITS]);
        n1_tag.isq   = (t_func'(i_req.func) == FUNC_QUERY);
        n1_tag.we    = (t_func'(i_req.func) == FUNC_LOAD) &&
                       (int'(i_req.load_row) < GRID_H) &&
                       (int'(i_req.load_col) < GRID_W);
        n1_tag.smp   = i_req.sample;
        n1_tag.fx    = i_req.longitude[FRAC_BITS-1:0];
        n1_tag.fy    = qpos[FRAC_BITS-1:0];
        n1_ucol      = UCW'(int'(ip) + KCOL);
        n1_urow      = URW'(int'(iq) + KROW);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_tag  <= n1_tag;
            r1_ucol <= n1_ucol;
            r1_urow <= n1_urow;
            r1_lrow <= i_req.load_row;
            r1_lcol <= i_req.load_col;
        end
    end

    // quotient estimate, low by at most one
    always_comb begin
        pcol = PCW'(r1_ucol) * PCW'(RCP_W);
        prow = PRW'(r1_urow) * PRW'(RCP_H);
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_tag  <= r1_tag;
            r2_ucol <= r1_ucol;
            r2_urow <= r1_urow;
            r2_qcol <= pcol[PCW-1:RECIP_SH];
            r2_qrow <= prow[PRW-1:RECIP_SH];
            r2_lrow <= r1_lrow;
            r2_lcol <= r1_lcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_tag  <= r2_tag;
            r3_rcol <= RMCW'(r2_ucol) - RMCW'(r2_qcol * GRID_W);
            r3_rrow <= RMRW'(r2_urow) - RMRW'(r2_qrow * GRID_H);
            r3_lrow <= r2_lrow;
            r3_lcol <= r2_lcol;
        end
    end

    // final correction and the wrapped neighbour
    always_comb begin
        c0 = (r3_rcol >= RMCW'(GRID_W)) ? CW'(r3_rcol - RMCW'(GRID_W)) : CW'(r3_rcol);
        w0 = (r3_rrow >= RMRW'(GRID_H)) ? RW'(r3_rrow - RMRW'(GRID_H)) : RW'(r3_rrow);
        c1 = (c0 == CW'(GRID_W - 1)) ? '0 : c0 + CW'(1);
        w1 = (w0 == RW'(GRID_H - 1)) ? '0 : w0 + RW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_tag <= r3_tag;
            r4_c0  <= r3_tag.isq ? c0 : CW'(r3_lcol);
            r4_r0  <= r3_tag.isq ? w0 : RW'(r3_lrow);
            r4_c1  <= c1;
            r4_r1  <= w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r5_tag   <= r4_tag;
            r5_base0 <= AW'(r4_r0 * GRID_W);
            r5_base1 <= AW'(r4_r1 * GRID_W);
            r5_c0    <= r4_c0;
            r5_c1    <= r4_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r6_tag     <= r5_tag;
            r6_addr[0] <= r5_base0 + AW'(r5_c0);
            r6_addr[1] <= r5_base0 + AW'(r5_c1);
            r6_addr[2] <= r5_base1 + AW'(r5_c0);
            r6_addr[3] <= r5_base1 + AW'(r5_c1);
        end
    end

endmodule

// ===== design/pgbl_table.sv =====
// ----------------------------------------------------------------------------
// pgbl_table
// Single-port height memory and its access sequencer: one write per in-grid
// load, four consecutive reads per query gathered into a sample set.
// ----------------------------------------------------------------------------
`include "periodic_grid_bilinear_lookup_unit_macros.svh"

module pgbl_table
    import pgbl_pkg::*;
#(
    parameter int GRID_W = DEF_GRID_W,
    parameter int GRID_H = DEF_GRID_H,
    parameter int AW     = $clog2(DEF_GRID_W * DEF_GRID_H)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_tag          i_tag,
    input  logic [AW-1:0] i_addr [NBR],
    output logic          o_set_valid,
    input  logic          i_set_ready,
    output t_set          o_set
);

    localparam int DEPTH  = GRID_W * GRID_H;
    localparam int CNT_W  = $clog2(NBR);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NBR - 1);

    t_smp             r_mem [DEPTH];
    t_smp             r_rdata;
    t_smp             r_slot [NBR-1];
    t_frac            r_fx;
    t_frac            r_fy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_set_v;
    logic             n_set_v;
    logic             issue_rd;
    logic             do_wr;

    // a new query starts only once the held set is gone or leaves now
    always_comb begin
        issue_rd = i_valid && i_tag.isq &&
                   ((r_cnt != '0) || !r_set_v || i_set_ready);
        do_wr    = i_valid && !i_tag.isq && i_tag.we;
        o_ready  = (i_valid && !i_tag.isq) || (issue_rd && (r_cnt == CNT_LAST));
        n_set_v  = (issue_rd && (r_cnt == CNT_LAST)) || (r_set_v && !i_set_ready);
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[i_addr[0]] <= i_tag.smp;
        end
        if (issue_rd) begin
            r_rdata <= r_mem[i_addr[r_cnt]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_rd && (r_cnt != '0)) begin
            r_slot[r_cnt - CNT_W'(1)] <= r_rdata;
        end
        if (issue_rd && (r_cnt == CNT_LAST)) begin
            r_fx <= i_tag.fx;
            r_fy <= i_tag.fy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_set_v <= 1'b0;
        end else begin
            if (issue_rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_set_v <= n_set_v;
        end
    end

    always_comb begin
        o_set_valid = r_set_v;
        o_set.a     = r_slot[0];
        o_set.b     = r_slot[1];
        o_set.c     = r_slot[2];
        o_set.d     = r_rdata;
        o_set.fx    = r_fx;
        o_set.fy    = r_fy;
    end

    `PGBL_ASSERT_IMP(a_no_wr_mid_query, r_cnt != '0, !do_wr, "write during neighbour reads")
    `PGBL_ASSERT_NXT(a_reads_back_to_back, r_cnt != '0, r_cnt != $past(r_cnt), "read burst stalled")
    `PGBL_ASSERT_NXT(a_set_held, r_set_v && !i_set_ready, r_set_v && $stable(r_rdata), "set lost")

endmodule

// ===== design/pgbl_blend.sv =====
// ----------------------------------------------------------------------------
// pgbl_blend
// Separable bilinear mix of a sample set, round to nearest, output register.
// ----------------------------------------------------------------------------
`include "periodic_grid_bilinear_lookup_unit_macros.svh"

module pgbl_blend
    import pgbl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_set_valid,
    output logic      o_set_ready,
    input  t_set      i_set,
    pgbl_out_if.source o_rsp
);

    localparam int NST   = 4;
    localparam int GW    = FRAC_BITS + 1;
    localparam int PW1   = 2 * SMP_W - 1;
    localparam int PW3   = PW1 + GW;
    localparam int SUM_W = PW3 + 1;
    localparam int RND   = 1 << (2 * FRAC_BITS - 1);

    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;

    logic [GW-1:0]           gx;
    logic [GW-1:0]           gy;
    logic signed [PW1-1:0]   n_pa;
    logic signed [PW1-1:0]   n_pb;
    logic signed [PW1-1:0]   n_pc;
    logic signed [PW1-1:0]   n_pd;
    logic signed [PW1-1:0]   r1_pa;
    logic signed [PW1-1:0]   r1_pb;
    logic signed [PW1-1:0]   r1_pc;
    logic signed [PW1-1:0]   r1_pd;
    logic [GW-1:0]           r1_gy;
    t_frac                   r1_fy;
    logic signed [PW1-1:0]   r2_top;
    logic signed [PW1-1:0]   r2_bot;
    logic [GW-1:0]           r2_gy;
    t_frac                   r2_fy;
    logic signed [PW3-1:0]   n_pt;
    logic signed [PW3-1:0]   n_pq;
    logic signed [PW3-1:0]   r3_pt;
    logic signed [PW3-1:0]   r3_pq;
    logic signed [SUM_W-1:0] n_sum;
    t_smp                    r_height;

    always_comb begin
        adv[NST-1] = !r_v[NST-1] || o_rsp.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_set_ready  = adv[0];
    assign o_rsp.valid  = r_v[NST-1];
    assign o_rsp.height = r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_set_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        gx   = GW'(FRAC_ONE) - GW'(i_set.fx);
        gy   = GW'(FRAC_ONE) - GW'(i_set.fy);
        n_pa = i_set.a * $signed({1'b0, gx});
        n_pb = i_set.b * $signed({1'b0, i_set.fx});
        n_pc = i_set.c * $signed({1'b0, gx});
        n_pd = i_set.d * $signed({1'b0, i_set.fx});
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_pa <= n_pa;
            r1_pb <= n_pb;
            r1_pc <= n_pc;
            r1_pd <= n_pd;
            r1_gy <= gy;
            r1_fy <= i_set.fy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_top <= r1_pa + r1_pb;
            r2_bot <= r1_pc + r1_pd;
            r2_gy  <= r1_gy;
            r2_fy  <= r1_fy;
        end
    end

    always_comb begin
        n_pt = r2_top * $signed({1'b0, r2_gy});
        n_pq = r2_bot * $signed({1'b0, r2_fy});
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_pt <= n_pt;
            r3_pq <= n_pq;
        end
    end

    // ties round up; floor falls out of the two's complement bit select
    always_comb begin
        n_sum = SUM_W'(r3_pt) + SUM_W'(r3_pq) + SUM_W'(RND);
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_height <= n_sum[SMP_W+2*FRAC_BITS-1:2*FRAC_BITS];
        end
    end

    `PGBL_ASSERT_IMP(a_out_from_pipe, $rose(r_v[NST-1]), $past(r_v[NST-2]), "result from nowhere")

endmodule

// ===== design/periodic_grid_bilinear_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_grid_bilinear_lookup_unit
// Geoid height table with bilinear lookup on a periodic grid.
//
// Load transactions (func 0) write one 16-bit sample into the GRID_H by
// GRID_W table; loads outside the grid are dropped. Query transactions
// (func 1) return one height, mixed from the four neighbours with 14-bit
// fractions and rounded to nearest, both indices wrapping around the grid.
// The table is not cleared at reset: every entry a query touches must have
// been loaded first. The single table port sets the rate: a load holds it
// for one write, a query for one read per neighbour, so loads run at one
// per cycle while no query holds the port, and all transactions stay in
// order. A query result passes the front address pipeline, the table
// reads and the blend pipeline; new transactions are taken while earlier
// ones are in flight or waiting at the output register.
// ----------------------------------------------------------------------------
module periodic_grid_bilinear_lookup_unit
    import pgbl_pkg::*;
#(
    parameter int GRID_W = DEF_GRID_W,
    parameter int GRID_H = DEF_GRID_H
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pgbl_in_if.sink    i_req,
    pgbl_out_if.source o_rsp
);

    localparam int AW = $clog2(GRID_W * GRID_H);

    logic          tbl_valid;
    logic          tbl_ready;
    t_tag          tbl_tag;
    logic [AW-1:0] tbl_addr [NBR];
    logic          set_valid;
    logic          set_ready;
    t_set          set_data;

    pgbl_front #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .AW     (AW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (tbl_valid),
        .i_ready (tbl_ready),
        .o_tag   (tbl_tag),
        .o_addr  (tbl_addr)
    );

    pgbl_table #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .AW     (AW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (tbl_valid),
        .o_ready     (tbl_ready),
        .i_tag       (tbl_tag),
        .i_addr      (tbl_addr),
        .o_set_valid (set_valid),
        .i_set_ready (set_ready),
        .o_set       (set_data)
    );

    pgbl_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set_valid (set_valid),
        .o_set_ready (set_ready),
        .i_set       (set_data),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== verif/height_lookup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_lookup_checker
// Watches the request and response channels of the periodic grid bilinear
// lookup unit, keeps its own copy of the height grid, predicts each query's
// interpolated height and compares it with the response transactions.
// ----------------------------------------------------------------------------
module height_lookup_checker
    import pgbl_pkg::*;
#(
    parameter int GRID_W = DEF_GRID_W,
    parameter int GRID_H = DEF_GRID_H
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pgbl_in_if   i_req,
    pgbl_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    t_smp height_grid [int];
    t_smp expected_heights [$];
    int   mismatches = 0;

    function automatic int wrap_index(input longint v, input int n);
        longint r;
        r = v % n;
        if (r < 0) begin
            r += n;
        end
        return int'(r);
    endfunction

    function automatic t_smp interpolate_height(input logic signed [LON_W-1:0] lon,
                                                input logic signed [LAT_W-1:0] lat);
        longint p, q, ip, iq, fx, fy, gx, gy, sum, h;
        longint a, b, c, d;
        int     c0, c1, r0, r1;
        p  = lon;
        q  = longint'(LAT_OFFSET) - longint'(lat);
        fx = p & (FRAC_ONE - 1);
        fy = q & (FRAC_ONE - 1);
        ip = p >>> FRAC_BITS;
        iq = q >>> FRAC_BITS;
        c0 = wrap_index(ip, GRID_W);
        c1 = wrap_index(ip + 1, GRID_W);
        r0 = wrap_index(iq, GRID_H);
        r1 = wrap_index(iq + 1, GRID_H);
        a  = height_grid[r0 * GRID_W + c0];
        b  = height_grid[r0 * GRID_W + c1];
        c  = height_grid[r1 * GRID_W + c0];
        d  = height_grid[r1 * GRID_W + c1];
        gx = FRAC_ONE - fx;
        gy = FRAC_ONE - fy;
        sum = a * gx * gy + b * fx * gy + c * gx * fy + d * fx * fy;
        h = (sum + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
        if (h > 32767) begin
            h = 32767;
        end
        if (h < -32768) begin
            h = -32768;
        end
        return t_smp'(h);
    endfunction

    always @(posedge i_clk) begin
        t_smp want;
        if (!i_rst_n) begin
            height_grid.delete();
            expected_heights.delete();
        end else begin
            // retire first: a result can never belong to a query taken this cycle
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_heights.size() == 0) begin
                    $display("%0t: unexpected height transaction, actual %0d",
                             $time, i_rsp.height);
                    mismatches++;
                end else begin
                    want = expected_heights.pop_front();
                    if (i_rsp.height !== want) begin
                        $display("%0t: height mismatch, expected %0d, actual %0d",
                                 $time, want, i_rsp.height);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (t_func'(i_req.func) == FUNC_LOAD) begin
                    if (int'(i_req.load_row) < GRID_H && int'(i_req.load_col) < GRID_W) begin
                        height_grid[int'(i_req.load_row) * GRID_W + int'(i_req.load_col)] =
                            i_req.sample;
                    end
                end else begin
                    expected_heights.push_back(
                        interpolate_height(i_req.longitude, i_req.latitude));
                end
            end
        end
        o_pending    <= expected_heights.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the periodic grid bilinear lookup unit: loads small patches
// of the height grid, including the wrapping corners, then queries only
// positions whose four neighbours are loaded, mixed with overwrites and
// out-of-grid loads, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import pgbl_pkg::*;

    localparam int GRID_W      = DEF_GRID_W;
    localparam int GRID_H      = DEF_GRID_H;
    localparam int NUM_ITEMS   = 650;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n;

    pgbl_in_if  req_if ();
    pgbl_out_if rsp_if ();

    int fail_count;
    int pending;
    int cycle_count;
    int items_sent;
    bit burst_mode;
    int anchor_rows [$];
    int anchor_cols [$];

    always #1 i_clk = ~i_clk;

    periodic_grid_bilinear_lookup_unit #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    height_lookup_checker #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= burst_mode || ($urandom_range(0, 99) >= 9);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_smp rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return t_smp'($urandom);
        endcase
    endfunction

    function automatic int rand_frac();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return FRAC_ONE - 1;
            2:       return FRAC_ONE / 2;
            default: return $urandom_range(0, FRAC_ONE - 1);
        endcase
    endfunction

    task automatic send_request(input t_func fn, input int row, input int col,
                                input t_smp smp, input int lon, input int lat);
        while (!burst_mode && $urandom_range(0, 99) < 9) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= fn;
        req_if.load_row  <= row[LROW_W-1:0];
        req_if.load_col  <= col[LCOL_W-1:0];
        req_if.sample    <= smp;
        req_if.longitude <= lon[LON_W-1:0];
        req_if.latitude  <= lat[LAT_W-1:0];
        do begin
            @(posedge i_clk);
        end while (req_if.ready !== 1'b1);
    endtask

    task automatic issue_load(input int row, input int col, input t_smp smp);
        send_request(FUNC_LOAD, row, col, smp, int'($urandom), int'($urandom));
        if (row < GRID_H && col < GRID_W) begin
            items_sent++;
        end
    endtask

    task automatic issue_query(input int lon, input int lat);
        send_request(FUNC_QUERY, int'($urandom), int'($urandom), t_smp'($urandom), lon, lat);
        items_sent++;
    endtask

    // four entries of the quad anchored at (r, c), in a random rotated order
    task automatic load_quad(input int r, input int c, input t_smp s00, input t_smp s01,
                             input t_smp s10, input t_smp s11);
        t_smp vals [4];
        int   start;
        int   idx;
        vals[0] = s00;
        vals[1] = s01;
        vals[2] = s10;
        vals[3] = s11;
        start = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
            idx = (start + k) % 4;
            issue_load((r + idx / 2) % GRID_H, (c + idx % 2) % GRID_W, vals[idx]);
        end
        anchor_rows.push_back(r);
        anchor_cols.push_back(c);
    endtask

    // column and row indices are chosen among their aliases across the wrap
    task automatic query_quad(input int r, input int c, input int fx, input int fy);
        int ip;
        int iq;
        ip = c;
        case ($urandom_range(0, 2))
            1: ip = c - GRID_W;
            2: if (c + GRID_W <= 2047) ip = c + GRID_W;
            default: ;
        endcase
        iq = r;
        if (r == 0 && fy == 0 && $urandom_range(0, 1) == 1) begin
            iq = GRID_H;
        end
        issue_query(ip * FRAC_ONE + fx, LAT_OFFSET - (iq * FRAC_ONE + fy));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic random_stimulus();
        int  sel;
        int  r;
        int  c;
        int  pick;
        int  corner;
        bit  drained_once;
        drained_once = 1'b0;
        while (items_sent < NUM_ITEMS) begin
            burst_mode = (items_sent >= 200 && items_sent < 350);
            if (!drained_once && items_sent >= 420) begin
                wait_drained();
                drained_once = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                r = $urandom_range(0, GRID_H - 1);
                c = $urandom_range(0, GRID_W - 1);
                case ($urandom_range(0, 7))
                    0: r = GRID_H - 1;
                    1: c = GRID_W - 1;
                    2: r = 0;
                    3: c = 0;
                    default: ;
                endcase
                load_quad(r, c, rand_sample(), rand_sample(), rand_sample(), rand_sample());
                repeat ($urandom_range(1, 3)) query_quad(r, c, rand_frac(), rand_frac());
            end else if (sel < 80) begin
                pick = $urandom_range(0, anchor_rows.size() - 1);
                repeat ($urandom_range(1, 2)) begin
                    query_quad(anchor_rows[pick], anchor_cols[pick], rand_frac(), rand_frac());
                end
            end else if (sel < 90) begin
                pick = $urandom_range(0, anchor_rows.size() - 1);
                corner = $urandom_range(0, 3);
                issue_load((anchor_rows[pick] + corner / 2) % GRID_H,
                           (anchor_cols[pick] + corner % 2) % GRID_W, rand_sample());
                query_quad(anchor_rows[pick], anchor_cols[pick], rand_frac(), rand_frac());
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 2))
                        0: issue_load($urandom_range(GRID_H, 1023),
                                      $urandom_range(0, 2047), rand_sample());
                        1: issue_load($urandom_range(0, GRID_H - 1),
                                      $urandom_range(GRID_W, 2047), rand_sample());
                        default: issue_load($urandom_range(GRID_H, 1023),
                                            $urandom_range(GRID_W, 2047), rand_sample());
                    endcase
                end
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        items_sent       = 0;
        burst_mode       = 1'b0;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.func      <= FUNC_LOAD;
        req_if.load_row  <= '0;
        req_if.load_col  <= '0;
        req_if.sample    <= '0;
        req_if.longitude <= '0;
        req_if.latitude  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // loads outside the grid are dropped
        issue_load(1023, 2047, rand_sample());
        issue_load(GRID_H, 5, rand_sample());
        issue_load(3, GRID_W, rand_sample());

        // corner quad wrapping in both directions, full-scale values
        load_quad(GRID_H - 1, GRID_W - 1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        issue_query(-1, LAT_OFFSET - ((GRID_H - 1) * FRAC_ONE + FRAC_ONE - 1));
        load_quad(GRID_H - 1, GRID_W - 1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        issue_query((GRID_W - 1) * FRAC_ONE, LAT_OFFSET - (GRID_H - 1) * FRAC_ONE);

        // extreme longitude and row index folding onto row 0, then ties at one half
        load_quad(0, 607, 16'sd1, 16'sd0, -16'sd1, 16'sd0);
        issue_query(33554431, -LAT_OFFSET);
        issue_query(607 * FRAC_ONE + FRAC_ONE / 2, LAT_OFFSET);
        issue_query(607 * FRAC_ONE, LAT_OFFSET - 3 * FRAC_ONE / 4);

        load_quad(0, 832, rand_sample(), rand_sample(), rand_sample(), rand_sample());
        issue_query(-33554432, LAT_OFFSET);

        wait_drained();
        random_stimulus();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pgbl_pkg.sv
design/pgbl_in_if.sv
design/pgbl_out_if.sv
design/pgbl_front.sv
design/pgbl_table.sv
design/pgbl_blend.sv
design/periodic_grid_bilinear_lookup_unit.sv
verif/height_lookup_checker.sv
verif/tb_top.sv
